### design/mf3x3_pkg.sv
// shared constants, types and codes of the 3x3 median filter
package mf3x3_pkg;

	// geometry limits
	localparam int MAX_LINE_DEF = 1024;
	localparam int WINDOW       = 3;
	localparam int MAX_ROWS     = 4096;

	// field and register widths
	localparam int PIX_W  = 8;
	localparam int WID_W  = 11;
	localparam int HGT_W  = 13;
	localparam int ROW_W  = 12;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register reset values
	localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

	// register indexes on the config port
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// column queue between front and back
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// request command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// one column pushed into the window, with its output tags
	typedef struct packed {
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bottom;
		logic             emit;
		logic             border;
		logic             last;
	} col_push_t;

endpackage

### design/mf3x3_in_if.sv
// input request channel: command and pixel
interface mf3x3_in_if import mf3x3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

### design/mf3x3_out_if.sv
// output request channel: filtered pixel and frame end mark
interface mf3x3_out_if import mf3x3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

### design/median_filter_3x3_stream.sv
// top level of the streaming 3x3 median filter with its register port
//
// Usage: pixels of a frame enter on in_ch in raster order, one request per
// pixel (cmd pixel) or one drain step (cmd flush, no pixel). Results leave on
// out_ch, one per image position, the last of a frame marked by frame_last.
// Interior positions give the median of the 3x3 neighborhood; positions on
// the first or last row or column give the pixel unchanged.
// Output position n is produced by input request n + width + 1, so a frame's
// tail comes out on the first width + 1 pixels of the next frame or on
// width + 1 flush steps after the frame. Flushes elsewhere are dropped.
// Throughput is one request per clock while out_ch takes results; each line
// store is read per pixel or drain step and written per pixel; the median
// network is three register stages. Registers: frame_width at 0x0,
// frame_height at 0x4, to be written by the user only while the block is
// idle; the block does not enforce this. Reset clears counters and window
// and sets 640 x 480. When out_ch stalls the back pipeline holds, the
// column queue fills and in_ch.ready drops; nothing is lost.
module median_filter_3x3_stream import mf3x3_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mf3x3_in_if.sink          in_ch,
	mf3x3_out_if.source       out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [WID_W-1:0]  frame_width_q;
	logic [HGT_W-1:0]  frame_height_q;
	reg_idx_t          reg_idx;
	logic              q_push, q_pop, q_empty;
	col_push_t         q_wdata, q_rdata;
	logic [QCNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[WID_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[HGT_W-1:0];
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
		endcase
	end

	mf3x3_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	mf3x3_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty),
		.count     (q_count)
	);

	mf3x3_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

### design/mf3x3_ram.sv
// generic single write port ram with registered read
module mf3x3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/mf3x3_queue.sv
// short fifo of window columns between front and back
module mf3x3_queue import mf3x3_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  col_push_t                  push_data,
	input  logic                       pop,
	output col_push_t                  pop_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	col_push_t       slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign pop_data = slot_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/mf3x3_front.sv
// front: request classification, raster counters and line stores
module mf3x3_front import mf3x3_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	mf3x3_in_if.sink           in_ch,
	input  logic [WID_W-1:0]   frame_width,
	input  logic [HGT_W-1:0]   frame_height,
	input  logic [QCNT_W-1:0]  q_count,
	output logic               q_push,
	output col_push_t          q_data
);

	localparam int CW = $clog2(MAX_LINE);
	localparam int WW = $clog2(MAX_LINE + 1);
	localparam int FW = $clog2(MAX_LINE + 2);

	logic [WW-1:0]    w;
	logic [HGT_W-1:0] h;
	logic [FW-1:0]    fill_full;

	// raster and drain state
	logic [CW-1:0]    in_col_q, in_col_n;
	logic [ROW_W-1:0] in_row_q, in_row_n;
	logic [FW-1:0]    fill_q, fill_n;
	logic [FW-1:0]    pending_q, pending_n;
	logic             drained_q, drained_n;
	logic [CW-1:0]    drain_col_q, drain_col_n;
	logic [CW-1:0]    out_col_q, out_col_n;
	logic [ROW_W-1:0] out_row_q, out_row_n;

	// effective counters for this request
	logic [FW-1:0]    fill_e, pend_e;
	logic [CW-1:0]    ocol_e;
	logic [ROW_W-1:0] orow_e;
	logic             col_end, row_end;

	// request decode
	logic             accept;
	logic             flush_live;
	logic             take;
	logic [CW-1:0]    col_n;
	logic [PIX_W-1:0] bottom_n;
	logic             wb_n, emit_n, border_n, last_n;

	// line store read stage
	logic             v_s1;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] bottom_s1;
	logic             wb_s1, emit_s1, border_s1, last_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fup_s1, fmid_s1;
	logic [PIX_W-1:0] up_rd, mid_rd;
	logic [PIX_W-1:0] up_res, mid_res;
	logic [QCNT_W-1:0] slots_used;

	// clamp configured geometry to the usable range
	always_comb begin
		if (frame_width == '0) begin
			w = WW'(1);
		end else if (32'(frame_width) > 32'(MAX_LINE)) begin
			w = WW'(MAX_LINE);
		end else begin
			w = WW'(frame_width);
		end
		if (frame_height == '0) begin
			h = HGT_W'(1);
		end else if (frame_height > HGT_W'(MAX_ROWS)) begin
			h = HGT_W'(MAX_ROWS);
		end else begin
			h = frame_height;
		end
		fill_full = FW'(w) + FW'(1);
	end

	// credit: queue entries plus the column in flight
	assign slots_used  = q_count + QCNT_W'(v_s1);
	assign in_ch.ready = (slots_used < QCNT_W'(QDEPTH));
	assign accept      = in_ch.valid && in_ch.ready;
	assign flush_live  = (in_col_q == '0) && (in_row_q == '0) && (pending_q != '0);

	// next raster state and column to push
	always_comb begin
		in_col_n    = in_col_q;
		in_row_n    = in_row_q;
		fill_n      = fill_q;
		pending_n   = pending_q;
		drained_n   = drained_q;
		drain_col_n = drain_col_q;
		fill_e      = fill_q;
		pend_e      = pending_q;
		ocol_e      = out_col_q;
		orow_e      = out_row_q;
		take        = 1'b0;
		col_n       = in_col_q;
		bottom_n    = in_ch.pixel_in;
		wb_n        = 1'b0;
		emit_n      = 1'b0;
		if (accept && (in_ch.cmd == CMD_PIXEL)) begin
			// a pixel after a partial drain drops the old tail
			if (drained_q) begin
				fill_e = '0;
				pend_e = '0;
				ocol_e = '0;
				orow_e = '0;
			end
			take = 1'b1;
			wb_n = 1'b1;
			if ((WW'(in_col_q) + WW'(1)) >= w) begin
				in_col_n = '0;
				if ((HGT_W'(in_row_q) + HGT_W'(1)) >= h) begin
					in_row_n = '0;
				end else begin
					in_row_n = in_row_q + ROW_W'(1);
				end
			end else begin
				in_col_n = in_col_q + CW'(1);
			end
			drained_n   = 1'b0;
			drain_col_n = '0;
			if (fill_e >= fill_full) begin
				emit_n    = 1'b1;
				fill_n    = fill_e;
				pending_n = pend_e;
			end else begin
				fill_n    = fill_e + FW'(1);
				pending_n = pend_e + FW'(1);
			end
		end else if (accept && flush_live) begin
			// drain step: empty bottom pixel, stores left as they are
			take      = 1'b1;
			col_n     = drain_col_q;
			bottom_n  = '0;
			drained_n = 1'b1;
			if ((WW'(drain_col_q) + WW'(1)) >= w) begin
				drain_col_n = '0;
			end else begin
				drain_col_n = drain_col_q + CW'(1);
			end
			if (fill_q >= fill_full) begin
				emit_n    = 1'b1;
				pending_n = pending_q - FW'(1);
				if (pending_q == FW'(1)) begin
					fill_n      = '0;
					drained_n   = 1'b0;
					drain_col_n = '0;
				end
			end else begin
				fill_n = fill_q + FW'(1);
			end
		end

		// output position tags
		row_end   = (HGT_W'(orow_e) + HGT_W'(1)) >= h;
		col_end   = (WW'(ocol_e) + WW'(1)) >= w;
		last_n    = row_end && col_end;
		border_n  = (orow_e == '0) || row_end || (ocol_e == '0) || col_end;
		out_col_n = ocol_e;
		out_row_n = orow_e;
		if (emit_n) begin
			if (last_n) begin
				out_col_n = '0;
				out_row_n = '0;
			end else if (col_end) begin
				out_col_n = '0;
				out_row_n = orow_e + ROW_W'(1);
			end else begin
				out_col_n = ocol_e + CW'(1);
			end
		end
	end

	// raster state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			fill_q      <= '0;
			pending_q   <= '0;
			drained_q   <= 1'b0;
			drain_col_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
		end else begin
			in_col_q    <= in_col_n;
			in_row_q    <= in_row_n;
			fill_q      <= fill_n;
			pending_q   <= pending_n;
			drained_q   <= drained_n;
			drain_col_q <= drain_col_n;
			out_col_q   <= out_col_n;
			out_row_q   <= out_row_n;
		end
	end

	// store data, with bypass of a write to the same column issued with the read
	assign up_res  = fwd_s1 ? fup_s1 : up_rd;
	assign mid_res = fwd_s1 ? fmid_s1 : mid_rd;

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1    <= col_n;
			bottom_s1 <= bottom_n;
			wb_s1     <= wb_n;
			emit_s1   <= emit_n;
			border_s1 <= border_n;
			last_s1   <= last_n;
			fwd_s1    <= v_s1 && wb_s1 && (col_s1 == col_n);
			fup_s1    <= mid_res;
			fmid_s1   <= bottom_s1;
		end
	end

	// line store two rows up
	mf3x3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE)
	) u_store_upper (
		.clk     (clk),
		.wr_en   (v_s1 && wb_s1),
		.wr_addr (col_s1),
		.wr_data (mid_res),
		.rd_en   (take),
		.rd_addr (col_n),
		.rd_data (up_rd)
	);

	// line store one row up
	mf3x3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_LINE)
	) u_store_lower (
		.clk     (clk),
		.wr_en   (v_s1 && wb_s1),
		.wr_addr (col_s1),
		.wr_data (bottom_s1),
		.rd_en   (take),
		.rd_addr (col_n),
		.rd_data (mid_rd)
	);

	// column into the queue
	assign q_push        = v_s1;
	assign q_data.up     = up_res;
	assign q_data.mid    = mid_res;
	assign q_data.bottom = bottom_s1;
	assign q_data.emit   = emit_s1;
	assign q_data.border = border_s1;
	assign q_data.last   = last_s1;

endmodule

### design/mf3x3_back.sv
// back: 3x3 window, pipelined median network and output register
module mf3x3_back import mf3x3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  col_push_t   q_data,
	output logic        q_pop,
	mf3x3_out_if.source out_ch
);

	typedef logic [WINDOW-1:0][PIX_W-1:0] trio_t;

	function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// ascending sort of three, index 0 is the smallest
	function automatic trio_t sort3(input logic [PIX_W-1:0] a, b, c);
		logic [PIX_W-1:0] lo1, hi1, lo2, hi2;
		trio_t            r;
		lo1  = min2(a, b);
		hi1  = max2(a, b);
		lo2  = min2(lo1, c);
		hi2  = max2(lo1, c);
		r[0] = lo2;
		r[1] = min2(hi1, hi2);
		r[2] = max2(hi1, hi2);
		return r;
	endfunction

	logic             adv;
	logic [PIX_W-1:0] win_q [WINDOW][WINDOW];

	logic             v_s1, border_s1, last_s1;
	logic             v_s2, border_s2, last_s2;
	trio_t            rows_s2 [WINDOW];
	logic [PIX_W-1:0] ctr_s2;
	logic             v_s3, border_s3, last_s3;
	logic [PIX_W-1:0] lo_s3, md_s3, hi_s3, ctr_s3;
	logic             out_v_q;
	logic [PIX_W-1:0] pix_q;
	logic             last_q;

	// whole back pipeline moves when the output register can take data
	assign adv   = !out_v_q || out_ch.ready;
	assign q_pop = adv && !q_empty;

	// window shift, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WINDOW; r++) begin
				for (int c = 0; c < WINDOW; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (q_pop) begin
			for (int r = 0; r < WINDOW; r++) begin
				for (int c = 0; c < WINDOW - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
			end
			win_q[0][WINDOW-1] <= q_data.up;
			win_q[1][WINDOW-1] <= q_data.mid;
			win_q[2][WINDOW-1] <= q_data.bottom;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= q_pop && q_data.emit;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	// median network stages and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			border_s1 <= q_data.border;
			last_s1   <= q_data.last;
			// sort each row
			for (int r = 0; r < WINDOW; r++) begin
				rows_s2[r] <= sort3(win_q[r][0], win_q[r][1], win_q[r][2]);
			end
			ctr_s2    <= win_q[1][1];
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			// largest minimum, middle median, smallest maximum
			lo_s3     <= max2(max2(rows_s2[0][0], rows_s2[1][0]), rows_s2[2][0]);
			md_s3     <= med3(rows_s2[0][1], rows_s2[1][1], rows_s2[2][1]);
			hi_s3     <= min2(min2(rows_s2[0][2], rows_s2[1][2]), rows_s2[2][2]);
			ctr_s3    <= ctr_s2;
			border_s3 <= border_s2;
			last_s3   <= last_s2;
			// border positions pass the centre pixel
			pix_q     <= border_s3 ? ctr_s3 : med3(lo_s3, md_s3, hi_s3);
			last_q    <= last_s3;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.pixel_out  = pix_q;
	assign out_ch.frame_last = last_q;

endmodule
